FILE: rtl/rtsd_pkg.sv
// Package for the record table: record, command and status types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package rtsd_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int ID_W         = 32;
   localparam int NAME_W       = 64;
   localparam int GRADE_W      = 9;
   localparam logic [GRADE_W-1:0] GRADE_MAX = 9'd400;

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_DELETE = 2'd1,
      FN_SORT   = 2'd2,
      FN_LIST   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WR_REQ = 2'd0,
      WR_A   = 2'd1,
      WR_B   = 2'd2
   } wr_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INSERT,
      S_DEL_START,
      S_DEL_RD,
      S_DEL_CHECK,
      S_DEL_SHIFT,
      S_DEL_MOVE,
      S_SORT_INIT,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_SWAP,
      S_SORT_NEXT,
      S_LIST_RD,
      S_LIST_OUT,
      S_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [NAME_W-1:0]  name;
      logic [GRADE_W-1:0] grade;
   } rec_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       count_inc;
      logic       count_dec;
      logic       out_load;
      logic       out_rec;
      logic       out_last;
      status_type out_status;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     id_match;
      logic     a_gt_b;
      logic     out_free;
   } stat_type;

endpackage

FILE: rtl/rtsd_ctrl.sv
// Record table sequencer: insert, delete, sort, list; one step a cycle unless stalled.
// Depends on rtsd_pkg; drives rtsd_dpath through command and address signals.
`timescale 1ns / 1ps

module rtsd_ctrl #(
   parameter int CAPACITY = rtsd_pkg::CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rtsd_pkg::stat_type stat,
   input  logic [CNT_W-1:0]   count,
   output rtsd_pkg::cmd_type  cmd,
   output logic [IDX_W-1:0]   rd_addr_a,
   output logic [IDX_W-1:0]   rd_addr_b,
   output logic [IDX_W-1:0]   wr_addr
);
   import rtsd_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   status_type       status_ff, status_in;
   logic [CNT_W-1:0] idx_nx;
   logic             full;

   assign idx_nx = CNT_W'(idx_ff) + CNT_W'(1);
   assign full   = (count == CNT_W'(CAPACITY));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      lim_ff    <= lim_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      lim_in    = lim_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (stat.func)
                  FN_INSERT: state_in = S_INSERT;
                  FN_DELETE: state_in = S_DEL_START;
                  FN_SORT:   state_in = S_SORT_INIT;
                  FN_LIST: begin
                     if (count == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESPOND;
                     end else begin
                        idx_in   = '0;
                        state_in = S_LIST_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INSERT: begin
            status_in = full ? ST_FULL : ST_OK;
            state_in  = S_RESPOND;
         end
         S_DEL_START: begin
            if (count == '0) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESPOND;
            end else begin
               idx_in   = '0;
               state_in = S_DEL_RD;
            end
         end
         S_DEL_RD: state_in = S_DEL_CHECK;
         S_DEL_CHECK: begin
            if (stat.id_match) begin
               state_in = S_DEL_SHIFT;
            end else if (idx_nx == count) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESPOND;
            end else begin
               idx_in   = idx_nx[IDX_W-1:0];
               state_in = S_DEL_RD;
            end
         end
         S_DEL_SHIFT: begin
            if (idx_nx < count) begin
               state_in = S_DEL_MOVE;
            end else begin
               status_in = ST_OK;
               state_in  = S_RESPOND;
            end
         end
         S_DEL_MOVE: begin
            idx_in   = idx_nx[IDX_W-1:0];
            state_in = S_DEL_SHIFT;
         end
         S_SORT_INIT: begin
            if (count < CNT_W'(2)) begin
               status_in = ST_OK;
               state_in  = S_RESPOND;
            end else begin
               lim_in   = count - CNT_W'(1);
               idx_in   = '0;
               state_in = S_SORT_RD;
            end
         end
         S_SORT_RD: state_in = S_SORT_CMP;
         S_SORT_CMP: state_in = stat.a_gt_b ? S_SORT_SWAP : S_SORT_NEXT;
         S_SORT_SWAP: state_in = S_SORT_NEXT;
         S_SORT_NEXT: begin
            if (idx_nx < lim_ff) begin
               idx_in   = idx_nx[IDX_W-1:0];
               state_in = S_SORT_RD;
            end else if (lim_ff == CNT_W'(1)) begin
               status_in = ST_OK;
               state_in  = S_RESPOND;
            end else begin
               lim_in   = lim_ff - CNT_W'(1);
               idx_in   = '0;
               state_in = S_SORT_RD;
            end
         end
         S_LIST_RD: state_in = S_LIST_OUT;
         S_LIST_OUT: begin
            if (stat.out_free) begin
               if (idx_nx == count) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_nx[IDX_W-1:0];
                  state_in = S_LIST_RD;
               end
            end
         end
         S_RESPOND: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.wr_sel = WR_REQ;
      cmd.out_status = ST_OK;
      rd_addr_a  = idx_ff;
      rd_addr_b  = idx_nx[IDX_W-1:0];
      wr_addr    = idx_ff;
      req_stall  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         S_INSERT: begin
            if (!full) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = WR_REQ;
               cmd.count_inc = 1'b1;
               wr_addr       = count[IDX_W-1:0];
            end
         end
         S_DEL_RD: cmd.rd_en = 1'b1;
         S_DEL_SHIFT: begin
            if (idx_nx < count) begin
               cmd.rd_en = 1'b1;
               rd_addr_a = idx_nx[IDX_W-1:0];
            end else begin
               cmd.count_dec = 1'b1;
            end
         end
         S_DEL_MOVE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_A;
         end
         S_SORT_RD: cmd.rd_en = 1'b1;
         S_SORT_CMP: begin
            if (stat.a_gt_b) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_B;
            end
         end
         S_SORT_SWAP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_A;
            wr_addr    = idx_nx[IDX_W-1:0];
         end
         S_LIST_RD: cmd.rd_en = 1'b1;
         S_LIST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_rec    = 1'b1;
               cmd.out_status = ST_OK;
               cmd.out_last   = (idx_nx == count);
            end
         end
         S_RESPOND: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = status_ff;
               cmd.out_last   = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/rtsd_dpath.sv
// Datapath for the record table: record memory, entry count, request and response registers.
// Depends on rtsd_pkg; steered by rtsd_ctrl.
`timescale 1ns / 1ps

module rtsd_dpath #(
   parameter int CAPACITY = rtsd_pkg::CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_func,
   input  logic [rtsd_pkg::ID_W-1:0]      req_student_id,
   input  logic [rtsd_pkg::NAME_W-1:0]    req_name_chars,
   input  logic [rtsd_pkg::GRADE_W-1:0]   req_grade,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [rtsd_pkg::ID_W-1:0]      rsp_out_id,
   output logic [rtsd_pkg::NAME_W-1:0]    rsp_out_name,
   output logic [rtsd_pkg::GRADE_W-1:0]   rsp_out_grade,
   output logic                           rsp_last,
   input  rtsd_pkg::cmd_type              cmd,
   input  logic [IDX_W-1:0]               rd_addr_a,
   input  logic [IDX_W-1:0]               rd_addr_b,
   input  logic [IDX_W-1:0]               wr_addr,
   output rtsd_pkg::stat_type             stat,
   output logic [CNT_W-1:0]               count
);
   import rtsd_pkg::*;

   rec_type          mem [CAPACITY];
   rec_type          rd_a_ff, rd_b_ff;
   rec_type          req_ff, req_in;
   rec_type          wr_data;
   logic [CNT_W-1:0] count_ff;
   logic             valid_ff;
   status_type       status_ff;
   rec_type          out_ff;
   logic             last_ff;

   always_comb begin
      req_in.id    = req_student_id;
      req_in.name  = req_name_chars;
      req_in.grade = (req_grade > GRADE_MAX) ? GRADE_MAX : req_grade;
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_REQ:  wr_data = req_ff;
         WR_A:    wr_data = rd_a_ff;
         WR_B:    wr_data = rd_b_ff;
         default: wr_data = req_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_in;
      end
      if (cmd.out_load) begin
         status_ff <= cmd.out_status;
         out_ff    <= cmd.out_rec ? rd_a_ff : '0;
         last_ff   <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign stat.func     = func_type'(req_func);
   assign stat.id_match = (rd_a_ff.id == req_ff.id);
   assign stat.a_gt_b   = (rd_a_ff.grade > rd_b_ff.grade);
   assign stat.out_free = !valid_ff || !rsp_stall;
   assign count         = count_ff;

   assign rsp_valid     = valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_id    = out_ff.id;
   assign rsp_out_name  = out_ff.name;
   assign rsp_out_grade = out_ff.grade;
   assign rsp_last      = last_ff;

endmodule

FILE: rtl/record_table_sort_delete_core.sv
// Record table with insert, delete by id, stable grade sort and list.
// Usage: one request beat on req_* (func, id, name, grade) yields one or more beats on rsp_*.
// Insert, delete and sort give one beat with last set; list gives one beat per record,
// last set on the final one, or a single "empty" beat for an empty table.
// Both channels: a beat moves when valid is high and stall is low.
// Steps per request (N = records held), paced by the single-write
// record memory and its registered read ports:
//   insert: a write at the end of the table, then the response beat.
//   delete: scans records for the id, shifts the later records down, then responds.
//   sort:   bubble sort, N(N-1)/2 compares, then the response beat.
//   list:   one read per record, then its beat.
// One request is in work at a time; req_stall is low only when the sequencer is idle.
// The next request is taken in the cycle after the response is loaded.
// A finished response waits in the output register while the next request is taken.
// Reset (synchronous, active high) empties the table and drops any pending response.
// While rsp_stall is high a valid response beat holds, and the sequencer waits before loading the next one.
// Depends on rtsd_pkg, rtsd_ctrl and rtsd_dpath.
`timescale 1ns / 1ps

module record_table_sort_delete_core #(
   parameter int CAPACITY = rtsd_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic [rtsd_pkg::ID_W-1:0]      req_student_id,
   input  logic [rtsd_pkg::NAME_W-1:0]    req_name_chars,
   input  logic [rtsd_pkg::GRADE_W-1:0]   req_grade,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [rtsd_pkg::ID_W-1:0]      rsp_out_id,
   output logic [rtsd_pkg::NAME_W-1:0]    rsp_out_name,
   output logic [rtsd_pkg::GRADE_W-1:0]   rsp_out_grade,
   output logic                           rsp_last
);
   import rtsd_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type          cmd;
   stat_type         stat;
   logic [CNT_W-1:0] count;
   logic [IDX_W-1:0] rd_addr_a;
   logic [IDX_W-1:0] rd_addr_b;
   logic [IDX_W-1:0] wr_addr;

   rtsd_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .count     (count),
      .cmd       (cmd),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_addr   (wr_addr)
   );

   rtsd_dpath #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_student_id (req_student_id),
      .req_name_chars (req_name_chars),
      .req_grade      (req_grade),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_name   (rsp_out_name),
      .rsp_out_grade  (rsp_out_grade),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .rd_addr_a      (rd_addr_a),
      .rd_addr_b      (rd_addr_b),
      .wr_addr        (wr_addr),
      .stat           (stat),
      .count          (count)
   );

endmodule
